>>> src/nfm_pkg.sv
// nfm_pkg: shared types and constants for the nearest fingerprint match unit.
// No dependencies; used by every module under src.
package nfm_pkg;

   localparam int REG_COUNT = 8;   // reference entry registers
   localparam int IDX_W     = 3;   // index into the reference entries
   localparam int SIG_W     = 8;   // one signal reading
   localparam int ENTRY_W   = 16;  // one reference pair
   localparam int DIST_W    = 9;   // full Manhattan distance of two bytes
   localparam int BEST_W    = 7;   // best distance kept (at most the limit)
   localparam int POS_W     = 4;   // 1-based entry number

   localparam logic [BEST_W-1:0] DIST_LIMIT = 7'd120;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HOLD
   } nfm_state_type;

   // sequencer to datapath control
   typedef struct packed {
      logic             clear;  // new request taken: capture readings, reset best
      logic             step;   // compare the entry at idx this cycle
      logic             load;   // move the final best into the output register
      logic [IDX_W-1:0] idx;    // entry under compare
   } nfm_ctl_type;

endpackage

>>> src/nearest_fingerprint_match_unit.sv
// nearest_fingerprint_match_unit: top level, reference entry registers and
// response register. Depends on nfm_pkg, nfm_seq and nfm_dist_unit.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | req_valid, req_stall, req_signal_a/b    | in
//  response| rsp_valid, rsp_stall, rsp_position,     | out
//          | rsp_found, rsp_best_distance            |
//  csr     | csr_write, csr_index, csr_wdata         | in
//
// A request first captures the readings, then feeds the reference entries,
// one entry per cycle, through the single abs-diff/add/compare unit.
// The response sits in an output register; the next request is taken while it
// waits; the scan parks at its end only if the register is full and stalled.
// Reset (synchronous) clears the entries to 0 and empties the pipeline.
// Entries should only be written while no request is in flight.
module nearest_fingerprint_match_unit #(
   parameter int NUM_ENTRIES = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [nfm_pkg::SIG_W-1:0]     req_signal_a,
   input  logic [nfm_pkg::SIG_W-1:0]     req_signal_b,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [nfm_pkg::POS_W-1:0]     rsp_position,
   output logic                          rsp_found,
   output logic [nfm_pkg::BEST_W-1:0]    rsp_best_distance,
   input  logic                          csr_write,
   input  logic [nfm_pkg::IDX_W-1:0]     csr_index,
   input  logic [nfm_pkg::ENTRY_W-1:0]   csr_wdata
);
   import nfm_pkg::*;

   logic [ENTRY_W-1:0] entry_ff [REG_COUNT];
   nfm_ctl_type        ctl;
   logic [POS_W-1:0]   pos_next;
   logic [BEST_W-1:0]  best_next;
   logic [POS_W-1:0]   pos_ff;
   logic [BEST_W-1:0]  best_ff;

   // reference entry registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) entry_ff[i] <= '0;
      end else if (csr_write) begin
         entry_ff[csr_index] <= csr_wdata;
      end
   end

   nfm_seq #(
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .ctl       (ctl)
   );

   nfm_dist_unit u_dist (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .signal_a  (req_signal_a),
      .signal_b  (req_signal_b),
      .entry     (entry_ff[ctl.idx]),
      .pos_next  (pos_next),
      .best_next (best_next)
   );

   // response payload register; loaded once per request
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         pos_ff  <= pos_next;
         best_ff <= best_next;
      end
   end

   assign rsp_position      = pos_ff;
   assign rsp_found         = pos_ff != '0;
   assign rsp_best_distance = best_ff;

   a_found_below_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_best_distance < DIST_LIMIT))
      else $error("found response with distance at or above limit");

endmodule

>>> src/nfm_dist_unit.sv
// nfm_dist_unit: shared distance and compare unit, one reference entry per cycle.
// Keeps the running best distance and position. Depends on nfm_pkg.
module nfm_dist_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  nfm_pkg::nfm_ctl_type     ctl,
   input  logic [nfm_pkg::SIG_W-1:0]   signal_a,
   input  logic [nfm_pkg::SIG_W-1:0]   signal_b,
   input  logic [nfm_pkg::ENTRY_W-1:0] entry,
   output logic [nfm_pkg::POS_W-1:0]   pos_next,
   output logic [nfm_pkg::BEST_W-1:0]  best_next
);
   import nfm_pkg::*;

   logic [SIG_W-1:0]  sig_a_ff, sig_a_in;
   logic [SIG_W-1:0]  sig_b_ff, sig_b_in;
   logic [BEST_W-1:0] best_ff, best_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SIG_W-1:0]  ent_a, ent_b, diff_a, diff_b;
   logic [DIST_W-1:0] man_dist;
   logic              hit;

   assign ent_a = entry[ENTRY_W-1:SIG_W];
   assign ent_b = entry[SIG_W-1:0];

   always_comb begin
      diff_a   = (sig_a_ff >= ent_a) ? (sig_a_ff - ent_a) : (ent_a - sig_a_ff);
      diff_b   = (sig_b_ff >= ent_b) ? (sig_b_ff - ent_b) : (ent_b - sig_b_ff);
      man_dist = {1'b0, diff_a} + {1'b0, diff_b};
      // strict compare: ties keep the lower entry
      hit      = man_dist < {{(DIST_W-BEST_W){1'b0}}, best_ff};
   end

   always_comb begin
      sig_a_in = sig_a_ff;
      sig_b_in = sig_b_ff;
      best_in  = best_ff;
      pos_in   = pos_ff;
      if (ctl.clear) begin
         sig_a_in = signal_a;
         sig_b_in = signal_b;
         best_in  = DIST_LIMIT;
         pos_in   = '0;
      end else if (ctl.step && hit) begin
         best_in  = man_dist[BEST_W-1:0];
         pos_in   = {{(POS_W-IDX_W){1'b0}}, ctl.idx} + POS_W'(1);
      end
   end

   assign pos_next  = pos_in;
   assign best_next = best_in;

   always_ff @(posedge clock) begin
      sig_a_ff <= sig_a_in;
      sig_b_ff <= sig_b_in;
      if (reset) begin
         best_ff <= DIST_LIMIT;
         pos_ff  <= '0;
      end else begin
         best_ff <= best_in;
         pos_ff  <= pos_in;
      end
   end

   a_best_in_range: assert property (@(posedge clock) disable iff (reset)
      best_ff <= DIST_LIMIT)
      else $error("best distance above limit");

   a_pos_matches_best: assert property (@(posedge clock) disable iff (reset)
      (pos_ff == '0) == (best_ff == DIST_LIMIT))
      else $error("position and best distance disagree");

endmodule

>>> src/nfm_seq.sv
// nfm_seq: sequencer stepping the shared distance unit over the entries,
// plus the response valid flag. Depends on nfm_pkg.
module nfm_seq #(
   parameter int NUM_ENTRIES = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output nfm_pkg::nfm_ctl_type ctl
);
   import nfm_pkg::*;

   localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_ENTRIES - 1);

   nfm_state_type    state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free, last;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign last     = idx_ff == LAST;

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (last) begin
               state_in = out_free ? ST_IDLE : ST_HOLD;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_HOLD: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = 1'b1;
      ctl       = '0;
      ctl.idx   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            ctl.clear = req_valid;
         end
         ST_SCAN: begin
            ctl.step = 1'b1;
            ctl.load = last && out_free;
         end
         ST_HOLD: begin
            ctl.load = out_free;
         end
         default: ;
      endcase
      rsp_valid_in = ctl.load || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff <= LAST))
      else $error("entry index past last entry");

   a_hold_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) |-> rsp_valid_ff)
      else $error("holding a result with an empty output register");

endmodule
